/* rtl/rpal_pkg.sv */
// Package for the point reflection pipeline: widths, status codes and sideband type.
`default_nettype none
package rpal_pkg;

  localparam int unsigned CW    = 32;          // coordinate width
  localparam int unsigned DW    = CW + 1;      // difference P - Q
  localparam int unsigned PW    = CW + DW;     // one n*d product
  localparam int unsigned SW    = PW + 2;      // n.d sum of three
  localparam int unsigned MW    = SW - 1;      // magnitude of n.d
  localparam int unsigned HW    = MW - DW;     // upper slice of |n.d|
  localparam int unsigned QW    = DW + 1;      // quotient bits, |q| <= |d|
  localparam int unsigned DENW  = 2 * CW;      // n.n
  localparam int unsigned NUMW  = DENW + QW;   // dividend width
  localparam int unsigned VW    = CW + 6;      // final sum before clipping

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // Per-item data that rides alongside the divider.
  typedef struct packed {
    logic [2:0][CW-1:0] q;
    logic [2:0][DW-1:0] d;
    logic [2:0]         n_neg;
    logic               s_neg;
    logic               zero;
  } side_t;

endpackage
`default_nettype wire

/* rtl/reflect_point_about_line.sv */
// Top level: pipelined reflection of a Q16.16 point about a line in 3-D.
`default_nettype none
// Reflects point Q about the line through P along direction n, one item per
// clock. start is taken whenever busy is low, and busy never rises, so a beat
// can be issued every cycle. Each result appears with done high for one cycle,
// after six stages form d, the dot products, |n.d| and the dividends, a
// 34-stage restoring divider yields one quotient bit per stage for all three
// components, and one stage clips and registers the result. The receiver
// cannot stall the block. A zero direction returns Q with status 1; any
// clipped component gives status 2.
module reflect_point_about_line (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic signed [31:0]        px,
  input  wire logic signed [31:0]        py,
  input  wire logic signed [31:0]        pz,
  input  wire logic signed [31:0]        dir_x,
  input  wire logic signed [31:0]        dir_y,
  input  wire logic signed [31:0]        dir_z,
  input  wire logic signed [31:0]        qx_in,
  input  wire logic signed [31:0]        qy_in,
  input  wire logic signed [31:0]        qz_in,
  output logic                           done,
  output logic signed [31:0]             rx,
  output logic signed [31:0]             ry,
  output logic signed [31:0]             rz,
  output logic [1:0]                     status
);

  localparam int unsigned CW   = rpal_pkg::CW;
  localparam int unsigned DW   = rpal_pkg::DW;
  localparam int unsigned PW   = rpal_pkg::PW;
  localparam int unsigned SW   = rpal_pkg::SW;
  localparam int unsigned MW   = rpal_pkg::MW;
  localparam int unsigned HW   = rpal_pkg::HW;
  localparam int unsigned QW   = rpal_pkg::QW;
  localparam int unsigned DENW = rpal_pkg::DENW;
  localparam int unsigned NUMW = rpal_pkg::NUMW;
  localparam int unsigned VW   = rpal_pkg::VW;

  assign busy = 1'b0;

  // Stage 1: capture, d = P - Q.
  logic               v1;
  logic signed [CW-1:0] n1 [3];
  logic signed [CW-1:0] q1 [3];
  logic signed [DW-1:0] d1 [3];

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= start;
    n1[0] <= dir_x; n1[1] <= dir_y; n1[2] <= dir_z;
    q1[0] <= qx_in; q1[1] <= qy_in; q1[2] <= qz_in;
    d1[0] <= DW'(px) - DW'(qx_in);
    d1[1] <= DW'(py) - DW'(qy_in);
    d1[2] <= DW'(pz) - DW'(qz_in);
  end

  // Stage 2: products n_i*d_i and n_i*n_i.
  logic                   v2;
  logic signed [CW-1:0]   n2 [3];
  logic signed [CW-1:0]   q2 [3];
  logic signed [DW-1:0]   d2 [3];
  logic signed [PW-1:0]   pd2 [3];
  logic signed [DENW-1:0] pn2 [3];

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    for (int j = 0; j < 3; j++) begin
      n2[j]  <= n1[j];
      q2[j]  <= q1[j];
      d2[j]  <= d1[j];
      pd2[j] <= PW'(n1[j]) * PW'(d1[j]);
      pn2[j] <= DENW'(n1[j]) * DENW'(n1[j]);
    end
  end

  // Stage 3: n.d and n.n.
  logic                   v3;
  logic signed [CW-1:0]   n3 [3];
  logic signed [CW-1:0]   q3 [3];
  logic signed [DW-1:0]   d3 [3];
  logic signed [SW-1:0]   s3;
  logic [DENW-1:0]        den3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    for (int j = 0; j < 3; j++) begin
      n3[j] <= n2[j];
      q3[j] <= q2[j];
      d3[j] <= d2[j];
    end
    s3   <= SW'(pd2[0]) + SW'(pd2[1]) + SW'(pd2[2]);
    den3 <= pn2[0] + pn2[1] + pn2[2];
  end

  // Stage 4: magnitudes and signs.
  logic                   v4;
  rpal_pkg::side_t        side4;
  logic [MW-1:0]          smag4;
  logic [CW-1:0]          nm4 [3];
  logic [DENW-1:0]        den4;
  logic signed [SW-1:0]   sneg3;
  logic signed [CW:0]     nneg3 [3];

  always_comb begin
    sneg3 = -s3;
    for (int j = 0; j < 3; j++) nneg3[j] = -(CW+1)'(n3[j]);
  end

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else v4 <= v3;
    for (int j = 0; j < 3; j++) begin
      side4.q[j]     <= q3[j];
      side4.d[j]     <= d3[j];
      side4.n_neg[j] <= n3[j][CW-1];
      nm4[j]         <= n3[j][CW-1] ? nneg3[j][CW-1:0] : n3[j];
    end
    side4.s_neg <= s3[SW-1];
    side4.zero  <= (den3 == '0);
    smag4       <= s3[SW-1] ? sneg3[MW-1:0] : s3[MW-1:0];
    den4        <= den3;
  end

  // Stage 5: partial products of |n.d| * |n_i|.
  logic                   v5;
  rpal_pkg::side_t        side5;
  logic [DENW-1:0]        den5;
  logic [DW+CW-1:0]       plo5 [3];
  logic [HW+CW-1:0]       phi5 [3];

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else v5 <= v4;
    side5 <= side4;
    den5  <= den4;
    for (int j = 0; j < 3; j++) begin
      plo5[j] <= (DW+CW)'(smag4[DW-1:0]) * (DW+CW)'(nm4[j]);
      phi5[j] <= (HW+CW)'(smag4[MW-1:DW]) * (HW+CW)'(nm4[j]);
    end
  end

  // Stage 6: dividends, loaded into the divider.
  logic            dvld  [QW+1];
  rpal_pkg::side_t dside [QW+1];
  logic [DENW-1:0] dden  [QW+1];
  logic [DENW-1:0] rem   [QW+1][3];
  logic [QW-1:0]   qacc  [QW+1][3];
  logic [NUMW-1:0] num5  [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      num5[j] = NUMW'(plo5[j]) + (NUMW'(phi5[j]) << DW);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) dvld[0] <= 1'b0;
    else dvld[0] <= v5;
    dside[0] <= side5;
    dden[0]  <= den5;
    for (int j = 0; j < 3; j++) begin
      rem[0][j]  <= num5[j][NUMW-1:QW];
      qacc[0][j] <= num5[j][QW-1:0];
    end
  end

  // Restoring divider: one quotient bit per stage; dividend bits shift out
  // of qacc as quotient bits shift in.
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [DENW:0] trial [3];
    logic [DENW:0] diff  [3];
    logic          ge    [3];

    always_comb begin
      for (int j = 0; j < 3; j++) begin
        trial[j] = {rem[k][j], qacc[k][j][QW-1]};
        diff[j]  = trial[j] - {1'b0, dden[k]};
        ge[j]    = trial[j] >= {1'b0, dden[k]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) dvld[k+1] <= 1'b0;
      else dvld[k+1] <= dvld[k];
      dside[k+1] <= dside[k];
      dden[k+1]  <= dden[k];
      for (int j = 0; j < 3; j++) begin
        rem[k+1][j]  <= ge[j] ? diff[j][DENW-1:0] : trial[j][DENW-1:0];
        qacc[k+1][j] <= {qacc[k][j][QW-2:0], ge[j]};
      end
    end
  end

  // Final stage: q + 2*(d - c), clipped to 32 bits.
  rpal_pkg::side_t     fs;
  logic signed [QW+1:0] cq   [3];
  logic signed [QW+1:0] dc   [3];
  logic signed [VW-1:0] vsum [3];
  logic signed [CW-1:0] clip [3];
  logic                 sat;

  localparam logic signed [VW-1:0] VMAX = VW'(2147483647);
  localparam logic signed [VW-1:0] VMIN = -VMAX - VW'(1);

  always_comb begin
    fs  = dside[QW];
    sat = 1'b0;
    for (int j = 0; j < 3; j++) begin
      cq[j] = (fs.n_neg[j] != fs.s_neg) ? -(QW+2)'(qacc[QW][j])
                                        : (QW+2)'(qacc[QW][j]);
      dc[j] = (QW+2)'($signed(fs.d[j])) - cq[j];
      vsum[j] = VW'($signed(fs.q[j])) + (VW'(dc[j]) <<< 1);
      if (vsum[j] > VMAX) begin
        clip[j] = CW'(VMAX);
        sat     = 1'b1;
      end else if (vsum[j] < VMIN) begin
        clip[j] = CW'(VMIN);
        sat     = 1'b1;
      end else begin
        clip[j] = vsum[j][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= dvld[QW];
    if (fs.zero) begin
      rx     <= fs.q[0];
      ry     <= fs.q[1];
      rz     <= fs.q[2];
      status <= rpal_pkg::ST_ZERO;
    end else begin
      rx     <= clip[0];
      ry     <= clip[1];
      rz     <= clip[2];
      status <= sat ? rpal_pkg::ST_SAT : rpal_pkg::ST_OK;
    end
  end

endmodule
`default_nettype wire

/* sim/tb_top.sv */
// Testbench for the point reflection pipeline: directed table, random beats, scoreboard.
module tb_top;

  typedef struct {
    logic signed [31:0] p [3];
    logic signed [31:0] n [3];
    logic signed [31:0] q [3];
  } pt_item_t;

  typedef struct {
    logic signed [31:0] r [3];
    logic [1:0]         st;
  } refl_t;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam logic signed [31:0] MAXV = 32'sh7fffffff;
  localparam logic signed [31:0] MINV = 32'sh80000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  logic signed [31:0] px = '0, py = '0, pz = '0;
  logic signed [31:0] dir_x = '0, dir_y = '0, dir_z = '0;
  logic signed [31:0] qx_in = '0, qy_in = '0, qz_in = '0;
  logic signed [31:0] rx, ry, rz;
  logic [1:0] status;

  refl_t reflect_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit timed_out = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  reflect_point_about_line dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .px(px), .py(py), .pz(pz),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
    .qx_in(qx_in), .qy_in(qy_in), .qz_in(qz_in),
    .done(done), .rx(rx), .ry(ry), .rz(rz), .status(status)
  );

  // Exact arithmetic at 200 bits; the quotient truncates toward zero like / does.
  function automatic refl_t reflect_point(pt_item_t it);
    logic signed [199:0] d [3];
    logic signed [199:0] nn [3];
    logic signed [199:0] dot, den, c, v;
    refl_t res;
    dot = 0;
    den = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = 200'(it.p[i]) - 200'(it.q[i]);
      nn[i] = 200'(it.n[i]);
      dot += nn[i] * d[i];
      den += nn[i] * nn[i];
    end
    if (den == 0) begin
      for (int i = 0; i < 3; i++) res.r[i] = it.q[i];
      res.st = rpal_pkg::ST_ZERO;
      return res;
    end
    res.st = rpal_pkg::ST_OK;
    for (int i = 0; i < 3; i++) begin
      c = (nn[i] * dot) / den;
      v = 200'(it.q[i]) + 2 * (d[i] - c);
      if (v > 200'(MAXV)) begin
        v = 200'(MAXV);
        res.st = rpal_pkg::ST_SAT;
      end else if (v < 200'(MINV)) begin
        v = 200'(MINV);
        res.st = rpal_pkg::ST_SAT;
      end
      res.r[i] = v[31:0];
    end
    return res;
  endfunction

  // Result side: the block cannot be held off, so every done cycle is one beat.
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (done) begin
        if (reflect_q.size() == 0) begin
          $display("%0t: unexpected result %h %h %h st=%0d", $time, rx, ry, rz, status);
          errors++;
        end else begin
          refl_t e;
          e = reflect_q.pop_front();
          if (rx !== e.r[0] || ry !== e.r[1] || rz !== e.r[2] || status !== e.st) begin
            $display("%0t: mismatch expected %h %h %h st=%0d actual %h %h %h st=%0d",
                     $time, e.r[0], e.r[1], e.r[2], e.st, rx, ry, rz, status);
            errors++;
          end
        end
      end
      if (idle_cycles >= STALL_LIMIT) timed_out <= 1;
    end
  end

  // Drives one beat and holds it until it is taken; start stays high across back-to-back beats.
  task automatic send_point(pt_item_t it, int gap_pct);
    int unsigned idle;
    idle = 0;
    while ($urandom_range(99) < gap_pct) idle++;
    if (idle > 0) begin
      start <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    {px, py, pz} <= {it.p[0], it.p[1], it.p[2]};
    {dir_x, dir_y, dir_z} <= {it.n[0], it.n[1], it.n[2]};
    {qx_in, qy_in, qz_in} <= {it.q[0], it.q[1], it.q[2]};
    start <= 1'b1;
    do @(posedge clk); while (busy);
    reflect_q.push_back(reflect_point(it));
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed(32'($urandom_range(0, 32'h1ffff))) - 32'sh10000;
      2: return $urandom_range(1) ? MAXV - $urandom_range(3) : MINV + $urandom_range(3);
      default: return $signed($urandom()) >>> $urandom_range(31);
    endcase
  endfunction

  function automatic pt_item_t rand_item();
    pt_item_t it;
    int mode;
    mode = $urandom_range(3);
    for (int i = 0; i < 3; i++) begin
      it.p[i] = rand_coord(mode);
      it.n[i] = rand_coord($urandom_range(3));
      it.q[i] = rand_coord(mode);
    end
    if ($urandom_range(19) == 0) it.n = '{0, 0, 0};
    else if ($urandom_range(9) == 0) it.n[$urandom_range(2)] = 0;
    return it;
  endfunction

  pt_item_t dir_tab[$];
  refl_t known_tab[$];
  bit has_known[$];

  task automatic add_row(pt_item_t it, bit known, refl_t e);
    dir_tab.push_back(it);
    has_known.push_back(known);
    known_tab.push_back(e);
  endtask

  initial begin
    pt_item_t it;
    refl_t e;
    int gap;
    // Zero direction returns Q unchanged.
    it.p = '{1, 2, 3}; it.n = '{0, 0, 0}; it.q = '{MAXV, MINV, -5};
    e.r = '{MAXV, MINV, -5}; e.st = rpal_pkg::ST_ZERO; add_row(it, 1, e);
    // Q on the line maps to itself.
    it.p = '{0, 0, 0}; it.n = '{32'sh10000, 0, 0}; it.q = '{32'sh30000, 0, 0};
    e.r = '{32'sh30000, 0, 0}; e.st = rpal_pkg::ST_OK; add_row(it, 1, e);
    // Half turn about the x axis.
    it.q = '{32'sh10000, 32'sh20000, -32'sh30000};
    e.r = '{32'sh10000, -32'sh20000, 32'sh30000}; e.st = rpal_pkg::ST_OK; add_row(it, 1, e);
    // Far away P drives x and y past the bounds; z lies along the line and stays put.
    it.p = '{MAXV, MAXV, MINV}; it.n = '{0, 0, 32'sh10000}; it.q = '{MINV, MINV, MAXV};
    e.r = '{MAXV, MAXV, MAXV}; e.st = rpal_pkg::ST_SAT; add_row(it, 1, e);
    it.p = '{MINV, MINV, MINV}; it.n = '{MINV, MINV, MINV}; it.q = '{MAXV, MAXV, MAXV};
    add_row(it, 0, e);
    it.n = '{MAXV, MINV, MAXV}; it.q = '{MAXV, MINV, 0}; add_row(it, 0, e);
    it.p = '{MAXV, MINV, 7}; it.n = '{-1, 1, -1}; it.q = '{-1, -1, -1}; add_row(it, 0, e);
    it.p = '{3, -7, 11}; it.n = '{3, 5, 0}; it.q = '{-2, 9, 1}; add_row(it, 0, e);
    it.p = '{-1, -1, -1}; it.n = '{32'sh55555555, 32'shaaaaaaaa, 1}; it.q = '{0, 0, 0};
    add_row(it, 0, e);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tab[k]) begin
      send_point(dir_tab[k], 0);
      if (has_known[k]) reflect_q[$] = known_tab[k];
    end
    start <= 1'b0;
    // Let the pipe drain completely before the random part.
    while (reflect_q.size() != 0 && !timed_out) @(negedge clk);
    @(negedge clk);

    for (int k = 0; k < 1150 && !timed_out; k++) begin
      case ((k / 100) % 4)
        0: gap = 0;
        1: gap = 47;
        2: gap = 25;
        default: gap = (k % 200 < 60) ? 0 : 47;
      endcase
      send_point(rand_item(), gap);
    end
    start <= 1'b0;

    while (reflect_q.size() != 0 && !timed_out) @(negedge clk);
    if (!timed_out) repeat (DRAIN_CYCLES) @(posedge clk);
    if (timed_out) begin
      $display("TB_ERROR");
    end else if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
